@@ rtl/olist_pkg.sv @@
// shared types and constants for the ordered list engine
// depends on nothing; used by ordered_list_engine_core and its testbench
package olist_pkg;

   localparam int unsigned Capacity = 64;

   typedef enum logic [3:0] {
      CMD_INS_HEAD = 4'd0,
      CMD_INS_TAIL = 4'd1,
      CMD_INS_POS  = 4'd2,
      CMD_DEL_HEAD = 4'd3,
      CMD_DEL_TAIL = 4'd4,
      CMD_DEL_POS  = 4'd5,
      CMD_DEL_VAL  = 4'd6,
      CMD_SEARCH   = 4'd7,
      CMD_LENGTH   = 4'd8,
      CMD_REVERSE  = 4'd9,
      CMD_READ_POS = 4'd10,
      CMD_READ_ALL = 4'd11,
      CMD_CLEAR    = 4'd12
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_EMPTY    = 3'd1,
      ST_RANGE    = 3'd2,
      ST_NOTFOUND = 3'd3,
      ST_FULL     = 3'd4
   } status_type;

   typedef struct packed {
      logic [3:0]         cmd;
      logic signed [31:0] item_value;
      logic [6:0]         position;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [31:0] out_value;
      logic [5:0]         found_index;
      logic [6:0]         list_length;
      logic               last;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_FREE_RD = 6'b000010,
      S_WALK    = 6'b000100,
      S_LINK_B  = 6'b001000,
      S_SWEEP   = 6'b010000,
      S_SPARE   = 6'b100000
   } state_type;

endpackage

@@ rtl/olist_node_ram.sv @@
// node pool storage: link and value memories, one write port each,
// shared read address with registered read data; depends on nothing
module olist_node_ram #(
   parameter int unsigned CAPACITY = 64,
   localparam int unsigned IDX_W = $clog2(CAPACITY),
   localparam int unsigned PTR_W = $clog2(CAPACITY + 1)
) (
   input  logic               clock,
   input  logic [IDX_W-1:0]   rd_addr,
   input  logic               link_we,
   input  logic [IDX_W-1:0]   link_wa,
   input  logic [PTR_W-1:0]   link_wd,
   input  logic               val_we,
   input  logic [IDX_W-1:0]   val_wa,
   input  logic [31:0]        val_wd,
   output logic [PTR_W-1:0]   link_q,
   output logic [31:0]        val_q
);

   logic [PTR_W-1:0] link_mem [CAPACITY];
   logic [31:0]      val_mem [CAPACITY];

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_wa] <= link_wd;
      end
      link_q <= link_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= val_wd;
      end
      val_q <= val_mem[rd_addr];
   end

endmodule

@@ rtl/ordered_list_engine_core.sv @@
// bounded singly linked list over a node pool with a free list
// depends on olist_pkg and olist_node_ram
//
// A command is taken when start is high and busy is low. Each command answers with
// one result word on rsp_data, marked by rsp_valid for one cycle; read-all answers
// with one word per element in list order, the final one with last set. The
// receiver cannot stall, so words must be taken as they appear. Positional and
// value commands walk the list one link per cycle through the pool memory read
// port. Length and rejected commands answer straight from idle, without a walk.
// After reset and after clear the link memory is rebuilt in a sweep pass during
// which busy stays high.
module ordered_list_engine_core #(
   parameter int unsigned CAPACITY = olist_pkg::Capacity
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  olist_pkg::req_type req_data,
   output logic              rsp_valid,
   output olist_pkg::rsp_type rsp_data
);

   localparam int unsigned IDX_W = $clog2(CAPACITY);
   localparam int unsigned PTR_W = $clog2(CAPACITY + 1);
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
   localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(CAPACITY);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

   olist_pkg::state_type state_ff, state_in;
   logic [3:0]       cmd_ff, cmd_in;
   logic [31:0]      val_ff, val_in;
   logic [CNT_W-1:0] tgt_ff, tgt_in;
   logic             ins0_ff, ins0_in;
   logic [PTR_W-1:0] node_ff, node_in;
   logic [PTR_W-1:0] prev_ff, prev_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] free_ff, free_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] fnext_ff, fnext_in;
   logic [PTR_W-1:0] newn_ff, newn_in;
   logic [PTR_W-1:0] wa_ff, wa_in;
   logic [PTR_W-1:0] wd_ff, wd_in;
   logic [IDX_W-1:0] sweep_ff, sweep_in;
   logic             rsp_valid_ff, rsp_valid_in;
   olist_pkg::rsp_type rsp_ff, rsp_in;

   logic [PTR_W-1:0] rd_ptr;
   logic             link_we, val_we;
   logic [PTR_W-1:0] link_wa;
   logic [PTR_W-1:0] link_wd;
   logic [PTR_W-1:0] link_q;
   logic [31:0]      val_q;

   logic [CMP_W-1:0] pos_x, cnt_x, p_x;
   logic             is_ins;

   olist_node_ram #(.CAPACITY(CAPACITY)) u_ram (
      .clock   (clock),
      .rd_addr (IDX_W'(rd_ptr)),
      .link_we (link_we),
      .link_wa (IDX_W'(link_wa)),
      .link_wd (link_wd),
      .val_we  (val_we),
      .val_wa  (IDX_W'(newn_ff)),
      .val_wd  (val_ff),
      .link_q  (link_q),
      .val_q   (val_q)
   );

   assign busy      = (state_ff != olist_pkg::S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign pos_x  = CMP_W'(req_data.position);
   assign cnt_x  = CMP_W'(count_ff);
   assign is_ins = (cmd_ff == olist_pkg::CMD_INS_HEAD) || (cmd_ff == olist_pkg::CMD_INS_TAIL)
                   || (cmd_ff == olist_pkg::CMD_INS_POS);

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      val_in   = val_ff;
      tgt_in   = tgt_ff;
      ins0_in  = ins0_ff;
      node_in  = node_ff;
      prev_in  = prev_ff;
      idx_in   = idx_ff;
      head_in  = head_ff;
      free_in  = free_ff;
      count_in = count_ff;
      fnext_in = fnext_ff;
      newn_in  = newn_ff;
      wa_in    = wa_ff;
      wd_in    = wd_ff;
      sweep_in = sweep_ff;
      rd_ptr   = node_ff;
      link_we  = 1'b0;
      link_wa  = wa_ff;
      link_wd  = wd_ff;
      val_we   = 1'b0;
      p_x      = '0;
      rsp_valid_in          = 1'b0;
      rsp_in.status         = olist_pkg::ST_OK;
      rsp_in.out_value      = '0;
      rsp_in.found_index    = '0;
      rsp_in.last           = 1'b1;
      rsp_in.list_length    = '0;

      case (state_ff)
         olist_pkg::S_IDLE: begin
            if (start) begin
               cmd_in  = req_data.cmd;
               val_in  = req_data.item_value;
               // walk setup, used by every walking command
               rd_ptr  = head_ff;
               node_in = head_ff;
               prev_in = NULL_PTR;
               idx_in  = '0;
               case (req_data.cmd)
                  olist_pkg::CMD_INS_HEAD, olist_pkg::CMD_INS_TAIL,
                  olist_pkg::CMD_INS_POS: begin
                     if (req_data.cmd == olist_pkg::CMD_INS_HEAD) begin
                        p_x = '0;
                     end else if (req_data.cmd == olist_pkg::CMD_INS_TAIL) begin
                        p_x = cnt_x;
                     end else begin
                        p_x = pos_x;
                     end
                     if (free_ff == NULL_PTR) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olist_pkg::ST_FULL;
                     end else if (p_x > cnt_x) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olist_pkg::ST_RANGE;
                     end else begin
                        rd_ptr   = free_ff;
                        newn_in  = free_ff;
                        ins0_in  = (p_x == '0);
                        tgt_in   = CNT_W'(p_x - CMP_W'(1));
                        state_in = olist_pkg::S_FREE_RD;
                     end
                  end
                  olist_pkg::CMD_DEL_HEAD, olist_pkg::CMD_DEL_TAIL,
                  olist_pkg::CMD_DEL_POS: begin
                     if (req_data.cmd == olist_pkg::CMD_DEL_HEAD) begin
                        p_x = '0;
                     end else if (req_data.cmd == olist_pkg::CMD_DEL_TAIL) begin
                        p_x = cnt_x - CMP_W'(1);
                     end else begin
                        p_x = pos_x;
                     end
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olist_pkg::ST_EMPTY;
                     end else if (p_x >= cnt_x) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olist_pkg::ST_RANGE;
                     end else begin
                        tgt_in   = CNT_W'(p_x);
                        state_in = olist_pkg::S_WALK;
                     end
                  end
                  olist_pkg::CMD_DEL_VAL, olist_pkg::CMD_READ_ALL: begin
                     if (count_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olist_pkg::ST_EMPTY;
                     end else begin
                        state_in = olist_pkg::S_WALK;
                     end
                  end
                  olist_pkg::CMD_SEARCH, olist_pkg::CMD_REVERSE: begin
                     state_in = olist_pkg::S_WALK;
                  end
                  olist_pkg::CMD_READ_POS: begin
                     if (pos_x >= cnt_x) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = olist_pkg::ST_RANGE;
                     end else begin
                        tgt_in   = CNT_W'(pos_x);
                        state_in = olist_pkg::S_WALK;
                     end
                  end
                  olist_pkg::CMD_CLEAR: begin
                     head_in      = NULL_PTR;
                     free_in      = '0;
                     count_in     = '0;
                     sweep_in     = '0;
                     rsp_valid_in = 1'b1;
                     state_in     = olist_pkg::S_SWEEP;
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end

         olist_pkg::S_FREE_RD: begin
            // link_q holds the successor of the node taken off the free list
            fnext_in = link_q;
            val_we   = 1'b1;
            if (ins0_ff) begin
               link_we      = 1'b1;
               link_wa      = newn_ff;
               link_wd      = head_ff;
               head_in      = newn_ff;
               free_in      = link_q;
               count_in     = count_ff + CNT_W'(1);
               rsp_valid_in = 1'b1;
               state_in     = olist_pkg::S_IDLE;
            end else begin
               rd_ptr   = head_ff;
               node_in  = head_ff;
               prev_in  = NULL_PTR;
               idx_in   = '0;
               state_in = olist_pkg::S_WALK;
            end
         end

         olist_pkg::S_WALK: begin
            // node_ff is element idx_ff; link_q and val_q are its entry
            rd_ptr  = link_q;
            node_in = link_q;
            prev_in = node_ff;
            idx_in  = idx_ff + CNT_W'(1);
            case (cmd_ff)
               olist_pkg::CMD_INS_HEAD, olist_pkg::CMD_INS_TAIL,
               olist_pkg::CMD_INS_POS: begin
                  if (idx_ff == tgt_ff) begin
                     link_we  = 1'b1;
                     link_wa  = newn_ff;
                     link_wd  = link_q;
                     wa_in    = node_ff;
                     wd_in    = newn_ff;
                     state_in = olist_pkg::S_LINK_B;
                  end
               end
               olist_pkg::CMD_DEL_HEAD, olist_pkg::CMD_DEL_TAIL,
               olist_pkg::CMD_DEL_POS, olist_pkg::CMD_DEL_VAL: begin
                  if ((cmd_ff == olist_pkg::CMD_DEL_VAL) && (idx_ff == count_ff)) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = olist_pkg::ST_NOTFOUND;
                     state_in      = olist_pkg::S_IDLE;
                  end else if (((cmd_ff == olist_pkg::CMD_DEL_VAL) && (val_q == val_ff))
                               || ((cmd_ff != olist_pkg::CMD_DEL_VAL) && (idx_ff == tgt_ff)))
                  begin
                     // unlink node_ff, then hand it to the free list
                     if (prev_ff == NULL_PTR) begin
                        head_in = link_q;
                     end else begin
                        link_we = 1'b1;
                        link_wa = prev_ff;
                        link_wd = link_q;
                     end
                     wa_in    = node_ff;
                     wd_in    = free_ff;
                     state_in = olist_pkg::S_LINK_B;
                  end
               end
               olist_pkg::CMD_SEARCH: begin
                  if (idx_ff == count_ff) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = olist_pkg::ST_NOTFOUND;
                     state_in      = olist_pkg::S_IDLE;
                  end else if (val_q == val_ff) begin
                     rsp_valid_in       = 1'b1;
                     rsp_in.found_index = 6'(idx_ff);
                     state_in           = olist_pkg::S_IDLE;
                  end
               end
               olist_pkg::CMD_READ_POS: begin
                  if (idx_ff == tgt_ff) begin
                     rsp_valid_in     = 1'b1;
                     rsp_in.out_value = val_q;
                     state_in         = olist_pkg::S_IDLE;
                  end
               end
               olist_pkg::CMD_READ_ALL: begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.out_value = val_q;
                  rsp_in.last      = (idx_ff == count_ff - CNT_W'(1));
                  if (rsp_in.last) begin
                     state_in = olist_pkg::S_IDLE;
                  end
               end
               olist_pkg::CMD_REVERSE: begin
                  if (idx_ff == count_ff) begin
                     head_in      = prev_ff;
                     rsp_valid_in = 1'b1;
                     state_in     = olist_pkg::S_IDLE;
                  end else begin
                     link_we = 1'b1;
                     link_wa = node_ff;
                     link_wd = prev_ff;
                  end
               end
               default: begin
                  state_in = olist_pkg::S_IDLE;
               end
            endcase
         end

         olist_pkg::S_LINK_B: begin
            link_we = 1'b1;
            if (is_ins) begin
               free_in  = fnext_ff;
               count_in = count_ff + CNT_W'(1);
            end else begin
               free_in  = wa_ff;
               count_in = count_ff - CNT_W'(1);
            end
            rsp_valid_in = 1'b1;
            state_in     = olist_pkg::S_IDLE;
         end

         olist_pkg::S_SWEEP: begin
            // rebuild the free chain, one entry a cycle
            link_we  = 1'b1;
            link_wa  = PTR_W'(sweep_ff);
            link_wd  = PTR_W'(sweep_ff) + PTR_W'(1);
            sweep_in = sweep_ff + IDX_W'(1);
            if (sweep_ff == LAST_IDX) begin
               state_in = olist_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = olist_pkg::S_IDLE;
         end
      endcase

      rsp_in.list_length = 7'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= olist_pkg::S_SWEEP;
         sweep_ff     <= '0;
         head_ff      <= NULL_PTR;
         free_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         head_ff      <= head_in;
         free_ff      <= free_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff   <= cmd_in;
      val_ff   <= val_in;
      tgt_ff   <= tgt_in;
      ins0_ff  <= ins0_in;
      node_ff  <= node_in;
      prev_ff  <= prev_in;
      idx_ff   <= idx_in;
      fnext_ff <= fnext_in;
      newn_ff  <= newn_in;
      wa_ff    <= wa_in;
      wd_ff    <= wd_in;
      rsp_ff   <= rsp_in;
   end

endmodule

@@ tb/sv/ordered_list_engine_core_test.sv @@
// testbench for ordered_list_engine_core: directed and random list commands
// depends on olist_pkg and the engine rtl; expected words come from a list-level shadow
module ordered_list_engine_core_test;
   import olist_pkg::*;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   ordered_list_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   always #4 clock = ~clock;

   // shadow of the list contents, head first
   logic signed [31:0] shadow_list[$];
   rsp_type            pending_words[$];
   int unsigned        error_count;
   int unsigned        words_checked;
   int unsigned        items_sent;
   int unsigned        idle_pct;

   function automatic void push_word(status_type st, logic signed [31:0] val,
                                     logic [5:0] idx, logic lst);
      rsp_type w;
      w.status      = st;
      w.out_value   = val;
      w.found_index = idx;
      w.list_length = 7'(shadow_list.size());
      w.last        = lst;
      pending_words.push_back(w);
   endfunction

   function automatic status_type list_insert(int unsigned p, logic signed [31:0] v);
      if (shadow_list.size() >= Capacity) return ST_FULL;
      if (p > shadow_list.size()) return ST_RANGE;
      shadow_list.insert(p, v);
      return ST_OK;
   endfunction

   function automatic status_type list_remove(int unsigned p);
      if (shadow_list.size() == 0) return ST_EMPTY;
      if (p >= shadow_list.size()) return ST_RANGE;
      shadow_list.delete(p);
      return ST_OK;
   endfunction

   // index of first match, or list size when absent
   function automatic int unsigned list_find(logic signed [31:0] v);
      foreach (shadow_list[i])
         if (shadow_list[i] == v) return i;
      return shadow_list.size();
   endfunction

   function automatic void predict_words(req_type r);
      status_type         st;
      int unsigned        k;
      logic signed [31:0] rev[$];
      st = ST_OK;
      case (r.cmd)
         CMD_INS_HEAD: st = list_insert(0, r.item_value);
         CMD_INS_TAIL: st = list_insert(shadow_list.size(), r.item_value);
         CMD_INS_POS:  st = list_insert(r.position, r.item_value);
         CMD_DEL_HEAD: st = list_remove(0);
         CMD_DEL_TAIL: st = (shadow_list.size() == 0) ? ST_EMPTY
                                                      : list_remove(shadow_list.size() - 1);
         CMD_DEL_POS:  st = list_remove(r.position);
         CMD_DEL_VAL: begin
            if (shadow_list.size() == 0) st = ST_EMPTY;
            else begin
               k = list_find(r.item_value);
               st = (k < shadow_list.size()) ? list_remove(k) : ST_NOTFOUND;
            end
         end
         CMD_SEARCH: begin
            k = list_find(r.item_value);
            if (k < shadow_list.size()) begin
               push_word(ST_OK, 0, 6'(k), 1'b1);
               return;
            end
            st = ST_NOTFOUND;
         end
         CMD_REVERSE: begin
            foreach (shadow_list[i]) rev.push_front(shadow_list[i]);
            shadow_list = rev;
         end
         CMD_READ_POS: begin
            if (r.position >= shadow_list.size()) st = ST_RANGE;
            else begin
               push_word(ST_OK, shadow_list[r.position], 0, 1'b1);
               return;
            end
         end
         CMD_READ_ALL: begin
            if (shadow_list.size() == 0) push_word(ST_EMPTY, 0, 0, 1'b1);
            foreach (shadow_list[i])
               push_word(ST_OK, shadow_list[i], 0, i == shadow_list.size() - 1);
            return;
         end
         CMD_CLEAR: shadow_list.delete();
         default: st = ST_OK;
      endcase
      push_word(st, 0, 0, 1'b1);
   endfunction

   // drives one word and returns in the step of the edge that takes it
   task automatic send_word(logic [3:0] c, logic signed [31:0] v, logic [6:0] p);
      req_type r;
      r.cmd        = c;
      r.item_value = v;
      r.position   = p;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      predict_words(r);
      items_sent++;
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // lower start and let every expected word arrive
   task automatic settle();
      start <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (Capacity + 8) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (pending_words.size() == 0) begin
            $display("%0t: unexpected word %p", $time, rsp_data);
            error_count++;
         end else begin
            rsp_type w;
            w = pending_words.pop_front();
            words_checked++;
            if (rsp_data.status !== w.status || rsp_data.out_value !== w.out_value ||
                rsp_data.found_index !== w.found_index ||
                rsp_data.list_length !== w.list_length || rsp_data.last !== w.last) begin
               $display("%0t: mismatch expected %p actual %p", $time, w, rsp_data);
               error_count++;
            end
         end
      end
   end

   task automatic test_empty_list();
      send_word(CMD_DEL_HEAD, 0, 0);
      send_word(CMD_DEL_TAIL, 0, 0);
      send_word(CMD_DEL_POS, 0, 0);
      send_word(CMD_DEL_VAL, 5, 0);
      send_word(CMD_SEARCH, 5, 0);
      send_word(CMD_READ_POS, 0, 0);
      send_word(CMD_READ_ALL, 0, 0);
      send_word(CMD_LENGTH, 0, 0);
      send_word(CMD_REVERSE, 0, 0);
      settle();
   endtask

   task automatic test_basic_ops();
      send_word(CMD_INS_HEAD, 32'sh7fffffff, 0);
      send_word(CMD_INS_TAIL, 32'sh80000000, 0);
      send_word(CMD_INS_POS, -1, 7'd1);
      send_word(CMD_INS_POS, 9, 7'd3);      // equal to length: appends
      send_word(CMD_INS_POS, 9, 7'd127);    // beyond length
      send_word(CMD_SEARCH, 9, 0);
      send_word(CMD_SEARCH, 42, 0);
      send_word(CMD_READ_POS, 0, 7'd2);
      send_word(CMD_READ_POS, 0, 7'd4);
      send_word(CMD_REVERSE, 0, 0);
      send_word(CMD_READ_ALL, 0, 0);
      send_word(CMD_DEL_VAL, 42, 0);
      send_word(CMD_DEL_VAL, -1, 0);
      send_word(CMD_DEL_POS, 0, 7'd3);
      send_word(CMD_DEL_POS, 0, 7'd1);
      send_word(CMD_DEL_TAIL, 0, 0);
      send_word(CMD_DEL_HEAD, 0, 0);
      send_word(4'd13, 0, 0);
      send_word(4'd14, 0, 0);
      send_word(4'd15, -1, 7'd127);
      send_word(CMD_CLEAR, 0, 0);
      send_word(CMD_READ_ALL, 0, 0);
      settle();
   endtask

   task automatic test_pool_full();
      for (int i = 0; i < Capacity; i++) send_word(CMD_INS_TAIL, i, 0);
      send_word(CMD_INS_HEAD, 1, 0);
      send_word(CMD_INS_POS, 1, 7'd127);    // full wins over range
      send_word(CMD_READ_POS, 0, 7'd63);
      send_word(CMD_SEARCH, 63, 0);
      send_word(CMD_REVERSE, 0, 0);
      send_word(CMD_READ_ALL, 0, 0);
      send_word(CMD_DEL_POS, 0, 7'd63);
      send_word(CMD_CLEAR, 0, 0);
      settle();
   endtask

   task automatic test_random(int unsigned count, int unsigned pct);
      logic [3:0]         c;
      logic signed [31:0] v;
      logic [6:0]         p;
      int unsigned        sel;
      idle_pct = pct;
      repeat (count) begin
         sel = $urandom_range(0, 99);
         // keep the list mostly mid-sized so walks get long
         if (sel < 30) c = (shadow_list.size() < 40) ? 4'($urandom_range(0, 2)) : CMD_DEL_POS;
         else if (sel < 45) c = 4'($urandom_range(3, 6));
         else if (sel < 60) c = CMD_SEARCH;
         else if (sel < 75) c = CMD_READ_POS;
         else if (sel < 82) c = CMD_REVERSE;
         else if (sel < 86) c = CMD_READ_ALL;
         else if (sel < 89) c = CMD_LENGTH;
         else if (sel < 91) c = CMD_CLEAR;
         else if (sel < 93) c = 4'($urandom_range(13, 15));
         else c = 4'($urandom_range(0, 12));
         v = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 15);
         if ($urandom_range(0, 4) == 0) p = 7'($urandom_range(0, 127));
         else p = 7'($urandom_range(0, shadow_list.size()));
         send_word(c, v, p);
      end
      settle();
   endtask

   initial begin
      clock         = 1'b0;
      reset         = 1'b1;
      start         = 1'b0;
      req_data      = '0;
      error_count   = 0;
      words_checked = 0;
      items_sent    = 0;
      idle_pct      = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_basic_ops();
      test_pool_full();
      test_random(16, 0);
      test_random(16, 74);
      test_random(16, 7);
      $display("covered %0d commands and %0d result words: empty, full, range and random mixes",
               items_sent, words_checked);
      if (error_count == 0) $display("PASS ordered_list_engine_core");
      else $display("FAIL ordered_list_engine_core");
      $finish;
   end

   initial begin
      #4000000;
      $display("FAIL ordered_list_engine_core");
      $finish;
   end

endmodule
